@@ src/plst_pkg.sv @@
// ---------------------------------------------------------------------------
// plst_pkg: shared types and constants of the positional list store
// Sizes of the element memory and the length counter, the action codes
// and the command and status records passed between top level and engine.
// ---------------------------------------------------------------------------
package plst_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int LEN_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 11;
   localparam int DATA_W   = 32;
   localparam int CMP_W    = (POS_W > LEN_W) ? POS_W : LEN_W;
   localparam int REQ_W    = 48;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_READ   = 2'd2,
      ACT_NOP    = 2'd3
   } act_type;

   typedef enum logic [1:0] {
      OP_SHIFT_UP   = 2'd0,
      OP_SHIFT_DOWN = 2'd1,
      OP_READ       = 2'd2,
      OP_NONE       = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_SHIFT   = 2'd1,
      ST_READ    = 2'd2,
      ST_DELIVER = 2'd3
   } state_type;

   typedef struct packed {
      logic              start;
      op_type            op;
      logic [ADDR_W-1:0] first_addr;
      logic [LEN_W-1:0]  count;
      logic [ADDR_W-1:0] pos;
      logic [DATA_W-1:0] value;
      logic              zero;
      logic              take;
   } cmd_type;

   typedef struct packed {
      logic              idle;
      logic              rd_valid;
      logic [DATA_W-1:0] rd_data;
   } status_type;

endpackage

@@ src/plst_engine.sv @@
// ---------------------------------------------------------------------------
// plst_engine: element memory and its shift sequencer
// Holds the element memory and walks it one entry per cycle to open or
// close a gap, reading one entry and writing the one before it in flight; it also reads single entries.
// ---------------------------------------------------------------------------
module plst_engine
   import plst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status
);

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   state_type         state_ff, state_in;
   logic              up_ff, up_in;
   logic              ins_ff, ins_in;
   logic              zero_ff, zero_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [DATA_W-1:0] value_ff, value_in;

   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic              walk_done;

   assign walk_done = (cnt_ff == '0) && !wr_pend_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               priority if (cmd.op == OP_READ) begin
                  state_in = ST_READ;
               end else if (cmd.op == OP_SHIFT_UP || cmd.op == OP_SHIFT_DOWN) begin
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SHIFT: begin
            if (walk_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (cmd.take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = rd_addr_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = wr_addr_ff;
      mem_wr_data = rd_data_ff;
      status.idle     = 1'b0;
      status.rd_valid = 1'b0;
      status.rd_data  = zero_ff ? '0 : rd_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            status.idle = 1'b1;
         end
         ST_SHIFT: begin
            mem_rd_en = (cnt_ff != '0);
            if (wr_pend_ff) begin
               mem_wr_en = 1'b1;
            end else if (cnt_ff == '0 && ins_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pos_ff;
               mem_wr_data = value_ff;
            end
         end
         ST_READ: begin
            mem_rd_en   = !zero_ff;
            mem_rd_addr = pos_ff;
         end
         ST_DELIVER: begin
            status.rd_valid = 1'b1;
         end
         default: begin
            status.idle = 1'b0;
         end
      endcase
   end

   always_comb begin
      up_in      = up_ff;
      ins_in     = ins_ff;
      zero_in    = zero_ff;
      cnt_in     = cnt_ff;
      rd_addr_in = rd_addr_ff;
      pos_in     = pos_ff;
      value_in   = value_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      if (state_ff == ST_IDLE && cmd.start) begin
         up_in      = (cmd.op == OP_SHIFT_UP);
         ins_in     = (cmd.op == OP_SHIFT_UP);
         zero_in    = cmd.zero;
         cnt_in     = cmd.count;
         rd_addr_in = cmd.first_addr;
         pos_in     = cmd.pos;
         value_in   = cmd.value;
      end else if (state_ff == ST_SHIFT && mem_rd_en) begin
         cnt_in     = cnt_ff - LEN_W'(1);
         rd_addr_in = up_ff ? rd_addr_ff - ADDR_W'(1) : rd_addr_ff + ADDR_W'(1);
         wr_pend_in = 1'b1;
         wr_addr_in = up_ff ? rd_addr_ff + ADDR_W'(1) : rd_addr_ff - ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wr_pend_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         wr_pend_ff <= wr_pend_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      up_ff      <= up_in;
      ins_ff     <= ins_in;
      zero_ff    <= zero_in;
      rd_addr_ff <= rd_addr_in;
      wr_addr_ff <= wr_addr_in;
      pos_ff     <= pos_in;
      value_ff   <= value_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   a_pend_in_shift: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> state_ff == ST_SHIFT)
      else $error("pending write outside a shift walk");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == ST_IDLE)
      else $error("command started while the engine is busy");

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> mem_wr_addr != mem_rd_addr)
      else $error("read and write of the same entry in one cycle");

   a_deliver_after_read: assert property (@(posedge clock) disable iff (reset)
      $rose(status.rd_valid) |-> $past(state_ff == ST_READ))
      else $error("result offered without a preceding memory read");

endmodule

@@ src/positional_list_store_top.sv @@
// ---------------------------------------------------------------------------
// positional_list_store_top: ordered list of signed words with positional
// insert, remove and read
// Channel  Direction  Transaction
// req_     in         one insert, remove or read request
// rsp_     out        one read result per read request
// A read holds req_tready low through the READ and DELIVER states; a waiting
// result in the output register stalls only a further read, which waits in DELIVER.
// An insert or a remove holds req_tready low while the engine moves the entries
// behind the position one place, then an insert writes its value; the element
// memory has one read and one write port and moves one entry per cycle.
// Reset clears the length, the output valid flag and the engine state.
// ---------------------------------------------------------------------------
module positional_list_store_top
   import plst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // action[1:0], position[12:2], at_end[13], value[45:14], unused[47:46]
   input  logic [REQ_W-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // read_value[31:0]
   output logic [DATA_W-1:0] rsp_tdata
);

   act_type           act;
   logic [POS_W-1:0]  req_pos;
   logic              req_at_end;
   logic [DATA_W-1:0] req_value;

   logic [LEN_W-1:0]  len_ff, len_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff;

   logic [CMP_W-1:0]  len_x;
   logic [CMP_W-1:0]  pos_x;
   logic              end_ok;
   logic              accept;
   cmd_type           cmd;
   status_type        status;

   assign act        = act_type'(req_tdata[1:0]);
   assign req_pos    = req_tdata[12:2];
   assign req_at_end = req_tdata[13];
   assign req_value  = req_tdata[45:14];

   assign req_tready = status.idle;
   assign accept     = req_tvalid && req_tready;
   assign len_x      = CMP_W'(len_ff);

   always_comb begin
      end_ok = 1'b1;
      pos_x  = CMP_W'(req_pos);
      if (req_at_end) begin
         if (act == ACT_INSERT) begin
            pos_x = len_x;
         end else if (len_ff == '0) begin
            end_ok = 1'b0;
         end else begin
            pos_x = len_x - CMP_W'(1);
         end
      end
   end

   always_comb begin
      cmd.start      = 1'b0;
      cmd.op         = OP_NONE;
      cmd.first_addr = '0;
      cmd.count      = '0;
      cmd.pos        = pos_x[ADDR_W-1:0];
      cmd.value      = req_value;
      cmd.zero       = 1'b0;
      cmd.take       = !rsp_valid_ff || rsp_tready;
      len_in         = len_ff;
      unique case (act)
         ACT_INSERT: begin
            if (pos_x <= len_x && len_x < CMP_W'(CAPACITY)) begin
               cmd.start      = accept;
               cmd.op         = OP_SHIFT_UP;
               cmd.first_addr = ADDR_W'(len_x - CMP_W'(1));
               cmd.count      = LEN_W'(len_x - pos_x);
               if (accept) begin
                  len_in = len_ff + LEN_W'(1);
               end
            end
         end
         ACT_REMOVE: begin
            if (end_ok && pos_x < len_x) begin
               cmd.start      = accept;
               cmd.op         = OP_SHIFT_DOWN;
               cmd.first_addr = ADDR_W'(pos_x + CMP_W'(1));
               cmd.count      = LEN_W'(len_x - pos_x - CMP_W'(1));
               if (accept) begin
                  len_in = len_ff - LEN_W'(1);
               end
            end
         end
         ACT_READ: begin
            cmd.start = accept;
            cmd.op    = OP_READ;
            cmd.zero  = !(end_ok && pos_x < len_x);
         end
         ACT_NOP: begin
            cmd.start = 1'b0;
         end
         default: begin
            cmd.start = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.take && status.rd_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && status.rd_valid) begin
         rsp_data_ff <= status.rd_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   plst_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status)
   );

endmodule

@@ verif/tb.sv @@
// ---------------------------------------------------------------------------
// tb: self-checking testbench for positional_list_store_top
// Sends insert, remove, read and no-op transactions with random gaps on both
// streams, keeps its own copy of the list and its length, and compares each
// read result in order with the value that the copy predicts.
// ---------------------------------------------------------------------------
module tb
   import plst_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;

   logic [DATA_W-1:0] list_copy [CAPACITY];
   int unsigned       list_len = 0;
   logic [DATA_W-1:0] pending_reads [$];
   int unsigned       failures = 0;
   bit                req_quiet = 1'b0;
   bit                rsp_quiet = 1'b0;

   positional_list_store_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void update_list(act_type act, logic [POS_W-1:0] pos_field,
                                       logic at_end, logic [DATA_W-1:0] value);
      int unsigned pos;
      int unsigned i;
      bit          in_range;
      pos      = pos_field;
      in_range = 1'b1;
      if (at_end) begin
         if (act == ACT_INSERT) begin
            pos = list_len;
         end else if (list_len == 0) begin
            in_range = 1'b0;
         end else begin
            pos = list_len - 1;
         end
      end
      case (act)
         ACT_INSERT: begin
            if (pos <= list_len && list_len < CAPACITY) begin
               for (i = list_len; i > pos; i--) list_copy[i] = list_copy[i - 1];
               list_copy[pos] = value;
               list_len++;
            end
         end
         ACT_REMOVE: begin
            if (in_range && pos < list_len) begin
               for (i = pos; i + 1 < list_len; i++) list_copy[i] = list_copy[i + 1];
               list_len--;
            end
         end
         ACT_READ: begin
            if (in_range && pos < list_len) begin
               pending_reads.push_back(list_copy[pos]);
            end else begin
               pending_reads.push_back('0);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] random_value();
      case ($urandom_range(0, 15))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_item(act_type act, logic [POS_W-1:0] pos, logic at_end,
                            logic [DATA_W-1:0] value);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0) req_quiet = !req_quiet;
      gap = req_quiet ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {2'b00, value, at_end, pos, act};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      update_list(act, pos, at_end, value);
   endtask

   task automatic test_empty_store();
      send_item(ACT_READ, 11'd0, 1'b0, '0);
      send_item(ACT_READ, 11'd0, 1'b1, '0);
      send_item(ACT_REMOVE, 11'd0, 1'b1, '0);
      send_item(ACT_REMOVE, 11'd0, 1'b0, '0);
      send_item(ACT_INSERT, 11'd1, 1'b0, 32'h1234_5678);
      send_item(ACT_NOP, 11'd0, 1'b0, 32'hFFFF_FFFF);
   endtask

   task automatic test_edit_operations();
      send_item(ACT_INSERT, 11'd0, 1'b0, 32'h8000_0000);
      send_item(ACT_INSERT, 11'h7FF, 1'b1, 32'h7FFF_FFFF);
      send_item(ACT_INSERT, 11'd1, 1'b0, 32'h0000_0000);
      send_item(ACT_INSERT, 11'd0, 1'b0, 32'hFFFF_FFFF);
      send_item(ACT_INSERT, 11'd4, 1'b0, 32'h0000_5A5A);
      send_item(ACT_INSERT, 11'd6, 1'b0, 32'hDEAD_BEEF);
      send_item(ACT_READ, 11'd0, 1'b0, '0);
      send_item(ACT_READ, 11'd2, 1'b0, '0);
      send_item(ACT_READ, 11'd4, 1'b0, '0);
      send_item(ACT_READ, 11'd5, 1'b0, '0);
      send_item(ACT_READ, 11'd0, 1'b1, '0);
      send_item(ACT_REMOVE, 11'd2, 1'b0, '0);
      send_item(ACT_REMOVE, 11'd0, 1'b1, '0);
      send_item(ACT_REMOVE, 11'd3, 1'b0, '0);
      send_item(ACT_READ, 11'd0, 1'b0, '0);
      send_item(ACT_READ, 11'd1, 1'b0, '0);
      send_item(ACT_READ, 11'd2, 1'b0, '0);
      send_item(ACT_READ, 11'd0, 1'b1, '0);
   endtask

   task automatic test_random_traffic(int unsigned item_count);
      int unsigned k;
      int unsigned pick;
      int unsigned pos;
      act_type     act;
      logic        at_end;
      for (k = 0; k < item_count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            act = ACT_NOP;
         end else if (pick < 44) begin
            act = (list_len > 48) ? ACT_REMOVE : ACT_INSERT;
         end else if (pick < 68) begin
            act = ACT_REMOVE;
         end else begin
            act = ACT_READ;
         end
         at_end = ($urandom_range(0, 6) == 0);
         pick   = $urandom_range(0, 19);
         if (pick == 0) begin
            pos = 1024;
         end else if (pick < 4) begin
            pos = $urandom_range(0, 1024);
         end else begin
            pos = $urandom_range(0, list_len + 1);
         end
         send_item(act, POS_W'(pos), at_end, random_value());
      end
   endtask

   initial begin : read_checker
      int unsigned       gap;
      logic [DATA_W-1:0] expected;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_quiet = !rsp_quiet;
         gap = rsp_quiet ? 0 : $urandom_range(0, 18);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         if (pending_reads.size() == 0) begin
            $error("read_value: expected no transaction, got %0d", $signed(rsp_tdata));
            failures++;
         end else begin
            expected = pending_reads.pop_front();
            if (rsp_tdata !== expected) begin
               $error("read_value: expected %0d, got %0d",
                      $signed(expected), $signed(rsp_tdata));
               failures++;
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_store();
      test_edit_operations();
      test_random_traffic(556);
      req_tvalid <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (1100) @(posedge clock);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

@@ positional_list_store_top.f @@
src/plst_pkg.sv
src/plst_engine.sv
src/positional_list_store_top.sv
verif/tb.sv
